// ===== sv/assert_macros.svh =====
// Assertion macros shared by the square root RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge, off while rst_n is low.
`define NSR_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition that must never be seen outside reset.
`define NSR_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ===== sv/nsr_pkg.sv =====
// Shared constants, types and helpers of the Newton square root block.
`timescale 1ns / 1ps
package nsr_pkg;

  localparam int WORD_W         = 32;
  localparam int FRAC_BITS      = 16;
  localparam int MAX_ITERATIONS = 32;
  localparam int COUNT_W        = 6;
  localparam int COUNT_RESET    = 10;

  // operand << FRAC_BITS
  localparam int DIVIDEND_W = WORD_W + FRAC_BITS;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);
  localparam int ITER_W     = $clog2(MAX_ITERATIONS + 1);

  typedef logic [WORD_W-1:0]     word_t;
  typedef logic [DIVIDEND_W-1:0] dividend_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_DIV,
    S_FINISH
  } nsr_state_t;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // number of division passes: clamp(count, 1, MAX_ITERATIONS) - 1
  function automatic logic [ITER_W-1:0] passes_for(input logic [COUNT_W-1:0] count);
    logic [ITER_W-1:0] res;
    if (count == '0) begin
      res = '0;
    end else if (32'(count) > MAX_ITERATIONS) begin
      res = ITER_W'(MAX_ITERATIONS - 1);
    end else begin
      res = ITER_W'(count - 1'b1);
    end
    return res;
  endfunction

endpackage

// ===== sv/nsr_divider.sv =====
// Radix-2 restoring divider, one quotient bit per clock.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module nsr_divider import nsr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  dividend_t dividend,
  input  word_t     divisor,
  output div_stat_t stat,
  output dividend_t quotient
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  word_t                rem_r, rem_nxt;
  word_t                dvs_r, dvs_nxt;
  dividend_t            quo_r, quo_nxt;

  logic [WORD_W:0] shifted;
  logic            fits;

  // partial remainder with next dividend bit brought in
  assign shifted = {rem_r, quo_r[DIVIDEND_W-1]};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIVIDEND_W);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? WORD_W'(shifted - {1'b0, dvs_r}) : shifted[WORD_W-1:0];
      quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

  `NSR_NEVER(a_div_done_busy, done_r && busy_r)
  `NSR_ASSERT(a_div_done_pulse, done_r |=> !done_r)
  `NSR_ASSERT(a_div_cnt_live, busy_r |-> cnt_r != '0)

endmodule

// ===== sv/newton_square_root.sv =====
// Top level: Newton-Raphson square root of an unsigned Q16.16 word.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Takes one unsigned Q16.16 word on the in_ channel and returns its square
// root estimate, also Q16.16, on the out_ channel. The first estimate is
// half the operand; each further estimate is x' = (x + (operand<<16)/x) >> 1,
// truncated, with a zero estimate used as one when it divides and a result
// above 2^32-1 saturated. cfg_iteration_count sets the total number of
// estimates (reset 10); 0 acts as 1 and values above 32 act as 32. It may be
// written only while the block is idle. Every division pass runs on the
// one shared radix-2 restoring divider at one quotient bit per clock, with
// a launch state before it and an estimate update when it is done; an
// operand of zero or a count of one skips the divider. One word is in
// flight at a time: in_ready is high only while the sequencer is idle. The
// finished result sits in an output register, and the sequencer becomes
// ready again as soon as that register has taken it.
module newton_square_root import nsr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [WORD_W-1:0]  in_operand,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [WORD_W-1:0]  out_root_estimate,
  // configuration
  input  logic               cfg_write_en,
  input  logic [COUNT_W-1:0] cfg_iteration_count
);

  nsr_state_t state_r, state_nxt;

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [ITER_W-1:0]  left_r, left_nxt;    // division passes still to run
  word_t              operand_r, operand_nxt;
  word_t              est_r, est_nxt;
  logic               out_valid_r, out_valid_nxt;
  word_t              out_data_r, out_data_nxt;

  logic      in_fire;
  logic      div_start;
  logic      finish_load;
  div_stat_t div_stat;
  dividend_t quotient;
  word_t     divisor;

  logic [DIVIDEND_W:0]   sum;
  logic [DIVIDEND_W-1:0] half;
  word_t                 step_est;

  assign in_fire = in_valid && in_ready;

  // zero estimate divides as one
  assign divisor = (est_r == '0) ? WORD_W'(1) : est_r;

  nsr_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({operand_r, FRAC_BITS'(0)}),
    .divisor  (divisor),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // Newton update with saturation to one word
  assign sum      = {1'b0, DIVIDEND_W'(est_r)} + {1'b0, quotient};
  assign half     = sum[DIVIDEND_W:1];
  assign step_est = (half[DIVIDEND_W-1:WORD_W] != '0) ? '1 : half[WORD_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_operand == '0 || passes_for(count_r) == '0) begin
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_START;
          end
        end
      end
      S_START: state_nxt = S_DIV;
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = (left_r == ITER_W'(1)) ? S_FINISH : S_START;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready    = 1'b0;
    div_start   = 1'b0;
    finish_load = 1'b0;
    case (state_r)
      S_IDLE:   in_ready = 1'b1;
      S_START:  div_start = 1'b1;
      S_DIV:    ;
      S_FINISH: finish_load = !out_valid_r || out_ready;
      default:  ;
    endcase
  end

  // datapath
  always_comb begin
    count_nxt     = cfg_write_en ? cfg_iteration_count : count_r;
    left_nxt      = left_r;
    operand_nxt   = operand_r;
    est_nxt       = est_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (in_fire) begin
      operand_nxt = in_operand;
      est_nxt     = in_operand >> 1;
      left_nxt    = passes_for(count_r);
    end

    if (state_r == S_DIV && div_stat.done) begin
      est_nxt  = step_est;
      left_nxt = left_r - 1'b1;
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (finish_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = est_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= COUNT_W'(COUNT_RESET);
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
    operand_r  <= operand_nxt;
    est_r      <= est_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_root_estimate = out_data_r;

  `NSR_ASSERT(a_start_free, div_start |-> !div_stat.busy)
  `NSR_ASSERT(a_done_in_div, div_stat.done |-> state_r == S_DIV)
  `NSR_ASSERT(a_left_div, state_r == S_START |-> left_r != '0)
  `NSR_ASSERT(a_accept_busy, in_fire |=> state_r != S_IDLE)

endmodule
